@@ src/ltu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ltu_pkg;

  // Calendar constants.
  localparam logic [12:0] EPOCH_YEAR         = 13'd1970;
  localparam logic [12:0] MAX_YEAR           = 13'd4096;
  localparam logic [10:0] LEAPS_BEFORE_EPOCH = 11'd477;
  localparam logic [19:0] DAYS_PER_YEAR      = 20'd365;
  localparam logic [31:0] SECS_PER_DAY       = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR      = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN       = 17'd60;
  localparam logic signed [6:0] HOURS_PER_DAY = 7'sd24;
  localparam logic [5:0]  MAX_MIN_SEC        = 6'd59;

  // Reciprocal of 25 scaled by 2^15; exact for dividends below 2^12.
  localparam logic [10:0] DIV25_RECIP = 11'd1311;
  localparam logic [10:0] TWENTY_FIVE = 11'd25;

  // Month numbers.
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_MAY = 4'd5;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_JUL = 4'd7;
  localparam logic [3:0] MONTH_AUG = 4'd8;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_OCT = 4'd10;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // One input beat: local broken-down time.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] timestamp;
    logic        valid_res;
  } result_t;

  // UTC calendar fields after the timezone shift.
  typedef struct packed {
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        ok;
  } cal_t;

  // Day number and seconds within the day.
  typedef struct packed {
    logic [19:0] days;
    logic [16:0] sec_of_day;
    logic        ok;
  } dcount_t;

  // Floor of x / 25 through a reciprocal multiply.
  function automatic logic [6:0] div25(input logic [10:0] x);
    logic [21:0] prod;
    prod = {11'b0, x} * {11'b0, DIV25_RECIP};
    return prod[21:15];
  endfunction

  // True when x is a multiple of 25.
  function automatic logic is_mult25(input logic [10:0] x);
    logic [10:0] back;
    back = 11'(div25(x)) * TWENTY_FIVE;
    return back == x;
  endfunction

  // Gregorian leap year test.
  function automatic logic is_leap(input logic [12:0] y);
    logic by4;
    logic by100;
    logic by400;
    by4   = (y[1:0] == 2'b00);
    by100 = by4 && is_mult25(y[12:2]);
    by400 = by4 && (y[3:2] == 2'b00) && is_mult25({2'b00, y[12:4]});
    return by4 && (!by100 || by400);
  endfunction

  // Days in a month; a month outside 1 to 12 counts as 31 days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of a month, non-leap.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      MONTH_JAN: d = 9'd0;
      MONTH_FEB: d = 9'd31;
      MONTH_MAR: d = 9'd59;
      MONTH_APR: d = 9'd90;
      MONTH_MAY: d = 9'd120;
      MONTH_JUN: d = 9'd151;
      MONTH_JUL: d = 9'd181;
      MONTH_AUG: d = 9'd212;
      MONTH_SEP: d = 9'd243;
      MONTH_OCT: d = 9'd273;
      MONTH_NOV: d = 9'd304;
      MONTH_DEC: d = 9'd334;
      default:   d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/local_time_to_unix_timestamp.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Converts a local calendar date and time into a Unix seconds count. The
// timezone register (signed hours ahead of UTC) is subtracted from the hour,
// borrowing or carrying one day across month and year ends by the Gregorian
// rules; the shifted fields are range checked, and an invalid beat returns
// timestamp 0 with valid_res low. One beat is accepted every clock cycle while
// the input is not stalled: the input register takes the beat, and the timezone
// adjust, the day count and the final seconds multiply into the result register
// each add one register stage after it.
// Stalls back up through the stages, so a waiting result never holds off an
// input while a stage is free.
// Write the timezone register only while the pipeline is empty.
module local_time_to_unix_timestamp (
  input  logic              clk,
  input  logic              rst,
  input  logic              tz_we,
  input  logic [4:0]        tz_wdata,
  input  logic              item_valid,
  output logic              item_stall,
  input  ltu_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output ltu_pkg::result_t  result
);

  logic signed [4:0] tz_hours;

  logic              s0_valid;
  ltu_pkg::item_t    s0;
  logic              s1_valid;
  ltu_pkg::cal_t     s1;
  logic              s2_valid;
  ltu_pkg::dcount_t  s2;

  ltu_pkg::cal_t     s1_next;
  ltu_pkg::dcount_t  s2_next;
  ltu_pkg::result_t  result_next;
  logic [31:0]       ts_full;

  logic              out_free;
  logic              s2_free;
  logic              s1_free;
  logic              s0_free;

  // A stage can load when it is empty or its beat moves on.
  always_comb begin
    out_free   = !result_valid || !result_stall;
    s2_free    = !s2_valid || out_free;
    s1_free    = !s1_valid || s2_free;
    s0_free    = !s0_valid || s1_free;
    item_stall = !s0_free;
  end

  ltu_adjust u_adjust (
    .item     (s0),
    .tz_hours (tz_hours),
    .cal      (s1_next)
  );

  ltu_daycount u_daycount (
    .cal (s1),
    .cnt (s2_next)
  );

  // Scale days to seconds and add the time of day, modulo 2^32.
  always_comb begin
    ts_full = {12'b0, s2.days} * ltu_pkg::SECS_PER_DAY + 32'(s2.sec_of_day);
    result_next.timestamp = s2.ok ? ts_full : 32'd0;
    result_next.valid_res = s2.ok;
  end

  // Control state: timezone register and stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      tz_hours     <= '0;
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (tz_we) begin
        tz_hours <= tz_wdata;
      end
      if (s0_free) begin
        s0_valid <= item_valid;
      end
      if (s1_free) begin
        s1_valid <= s0_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        result_valid <= s2_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s0_free && item_valid) begin
      s0 <= item;
    end
    if (s1_free && s0_valid) begin
      s1 <= s1_next;
    end
    if (s2_free && s1_valid) begin
      s2 <= s2_next;
    end
    if (out_free && s2_valid) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // An invalid result always carries a zero timestamp.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.valid_res |-> result.timestamp == 32'd0)
    else $error("invalid result with nonzero timestamp");

  // The timezone shift always leaves the hour inside one day.
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1.hour < 5'd24)
    else $error("adjusted hour out of range");

  // A new result only appears when the day count stage held a beat.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s2_valid))
    else $error("result appeared without a beat in the last stage");

  // The input side stalls only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s0_valid && s1_valid && s2_valid && result_valid)
    else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire

@@ src/ltu_adjust.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ltu_adjust (
  input  ltu_pkg::item_t    item,
  input  logic signed [4:0] tz_hours,
  output ltu_pkg::cal_t     cal
);

  logic signed [6:0] tz_ext;
  logic signed [6:0] h_raw;
  logic signed [6:0] h_adj;
  logic              borrow;
  logic              carry;
  logic              leap_in;
  logic [4:0]        len_cur;
  logic [5:0]        day_inc;
  logic [4:0]        day_dec;
  logic [12:0]       yr;
  logic [3:0]        mo;
  logic [4:0]        dy;

  // Shift the hour by the timezone and detect a day borrow or carry.
  always_comb begin
    tz_ext  = {{2{tz_hours[4]}}, tz_hours};
    h_raw   = signed'({2'b00, item.hour}) - tz_ext;
    borrow  = h_raw[6];
    carry   = !h_raw[6] && (h_raw >= ltu_pkg::HOURS_PER_DAY);
    if (borrow) begin
      h_adj = h_raw + ltu_pkg::HOURS_PER_DAY;
    end else if (carry) begin
      h_adj = h_raw - ltu_pkg::HOURS_PER_DAY;
    end else begin
      h_adj = h_raw;
    end
  end

  // Move the date by one day across month and year ends.
  always_comb begin
    leap_in = ltu_pkg::is_leap({1'b0, item.year});
    len_cur = ltu_pkg::month_len(item.month, leap_in);
    day_inc = {1'b0, item.day} + 6'd1;
    day_dec = item.day - 5'd1;
    yr      = {1'b0, item.year};
    mo      = item.month;
    dy      = item.day;
    if (borrow) begin
      // Day zero stays zero and so stays invalid.
      if (item.day != 5'd0) begin
        if (day_dec == 5'd0) begin
          if (item.month == ltu_pkg::MONTH_JAN) begin
            mo = ltu_pkg::MONTH_DEC;
            yr = yr - 13'd1;
          end else if (item.month >= ltu_pkg::MONTH_FEB &&
                       item.month <= ltu_pkg::MONTH_DEC) begin
            mo = item.month - 4'd1;
          end
          // The year only changes into December, so the input year decides February.
          dy = ltu_pkg::month_len(mo, leap_in);
        end else begin
          dy = day_dec;
        end
      end
    end else if (carry) begin
      if (day_inc > {1'b0, len_cur}) begin
        dy = 5'd1;
        if (item.month == ltu_pkg::MONTH_DEC) begin
          mo = ltu_pkg::MONTH_JAN;
          yr = yr + 13'd1;
        end else if (item.month >= ltu_pkg::MONTH_JAN &&
                     item.month <= ltu_pkg::MONTH_NOV) begin
          mo = item.month + 4'd1;
        end
      end else begin
        dy = day_inc[4:0];
      end
    end
  end

  // Range checks on the shifted fields. A year borrowed below zero wraps high.
  always_comb begin
    cal.year   = yr;
    cal.month  = mo;
    cal.day    = dy;
    cal.hour   = h_adj[4:0];
    cal.minute = item.minute;
    cal.second = item.second;
    cal.ok     = (yr >= ltu_pkg::EPOCH_YEAR) && (yr <= ltu_pkg::MAX_YEAR) &&
                 (mo >= ltu_pkg::MONTH_JAN) && (mo <= ltu_pkg::MONTH_DEC) &&
                 (dy != 5'd0) &&
                 (item.minute <= ltu_pkg::MAX_MIN_SEC) &&
                 (item.second <= ltu_pkg::MAX_MIN_SEC);
  end

endmodule

`default_nettype wire

@@ src/ltu_daycount.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ltu_daycount (
  input  ltu_pkg::cal_t    cal,
  output ltu_pkg::dcount_t cnt
);

  logic [12:0] yprev;
  logic [12:0] yoff;
  logic [19:0] ydays;
  logic [6:0]  q100;
  logic [6:0]  q400;
  logic [10:0] leaps;
  logic        extra;

  // Whole years since the epoch plus leap days in the years before this one.
  always_comb begin
    yprev = cal.year - 13'd1;
    yoff  = cal.year - ltu_pkg::EPOCH_YEAR;
    ydays = 20'(yoff[11:0]) * ltu_pkg::DAYS_PER_YEAR;
    q100  = ltu_pkg::div25({1'b0, yprev[11:2]});
    q400  = ltu_pkg::div25({3'b000, yprev[11:4]});
    leaps = 11'(yprev[11:2]) - 11'(q100) + 11'(q400) - ltu_pkg::LEAPS_BEFORE_EPOCH;
    extra = (cal.month > ltu_pkg::MONTH_FEB) && ltu_pkg::is_leap(cal.year);
  end

  // Day number within the epoch and seconds within the day.
  always_comb begin
    cnt.days = ydays + 20'(leaps) + 20'(ltu_pkg::days_before(cal.month)) +
               20'(extra) + 20'(cal.day) - 20'd1;
    cnt.sec_of_day = 17'(cal.hour) * ltu_pkg::SECS_PER_HOUR +
                     17'(cal.minute) * ltu_pkg::SECS_PER_MIN +
                     17'(cal.second);
    cnt.ok = cal.ok;
  end

endmodule

`default_nettype wire
